// File: hw/rtl/lc3_pkg.sv
// Shared types and constants for the LC-3 instruction stepping core.
// No dependencies; used by the datapath, the RAM wrapper users and the top level.
package lc3_pkg;

  localparam logic [15:0] HaltWord = 16'hF025;
  localparam logic [2:0]  CcN      = 3'b100;
  localparam logic [2:0]  CcZ      = 3'b010;
  localparam logic [2:0]  CcP      = 3'b001;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_BR   = 4'h0,
    OP_ADD  = 4'h1,
    OP_LD   = 4'h2,
    OP_ST   = 4'h3,
    OP_JSR  = 4'h4,
    OP_AND  = 4'h5,
    OP_LDR  = 4'h6,
    OP_STR  = 4'h7,
    OP_RTI  = 4'h8,
    OP_NOT  = 4'h9,
    OP_LDI  = 4'hA,
    OP_STI  = 4'hB,
    OP_JMP  = 4'hC,
    OP_RES  = 4'hD,
    OP_LEA  = 4'hE,
    OP_TRAP = 4'hF
  } opcode_e;

  // Result beat fields, highest first in tdata.
  typedef struct packed {
    logic [15:0] store_value;
    logic [15:0] store_address;
    logic        mem_written;
    logic [15:0] reg_value;
    logic [2:0]  reg_number;
    logic        reg_written;
    logic        halted;
    logic [2:0]  cond_code;
    logic [15:0] fetched_word;
    logic [15:0] pc_after;
    logic [15:0] read_data;
  } result_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] cc;
    if (v == 16'h0000) cc = CcZ;
    else if (v[15])    cc = CcN;
    else               cc = CcP;
    return cc;
  endfunction

endpackage

// File: hw/rtl/lc3_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module lc3_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hw/rtl/lc3_instruction_step.sv
// LC-3 style core stepping one command per input beat.
// Path, input beat to result beat: an unused command answers in S_IDLE; a write or read passes
// S_FETCH; a step fetches in S_FETCH and decodes in S_DECODE (all that register ops, branches,
// jumps, LEA and traps need), then uses S_PTR for LDI/STI, S_DATA for loads and stores, S_DONE.
// One command at a time: the next beat is taken the cycle after the result beat leaves.
// Reset (async, active low): registers zero, PC = start_pc (0x3000), CC = Z.
// Memory contents are undefined until written; no clearing pass.
module lc3_instruction_step
  import lc3_pkg::*;
#(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd[1:0], mem_address[17:2], mem_data[33:18], zero pad to 40
  input  logic [39:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: read_data, pc_after, fetched_word, cond_code, halted, reg_written,
  // reg_number, reg_value, mem_written, store_address, store_value; pad to 112
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  localparam int AW = MEM_ADDR_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DECODE, S_PTR, S_DATA, S_DONE
  } state_e;

  state_e      state_q;
  logic [15:0] pc_q, ir_q, maddr_q, mdata_q, ptr_q;
  logic [2:0]  cc_q;
  logic [1:0]  cmd_q;
  logic        wait_q;
  logic [15:0] rf_q [8];
  result_t     res_q;
  logic        ovalid_q;

  // Shared memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;

  lc3_ram #(.Width(16), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign cfg_ready_o   = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, res_q};

  // Decode fields
  opcode_e     op;
  logic [2:0]  dr;
  logic [15:0] s1, v2, pc9, br6, pc11;
  assign op   = opcode_e'(ir_q[15:12]);
  assign dr   = ir_q[11:9];
  assign s1   = rf_q[ir_q[8:6]];
  assign v2   = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : rf_q[ir_q[2:0]];
  assign pc9  = pc_q + {{7{ir_q[8]}}, ir_q[8:0]};
  assign br6  = s1 + {{10{ir_q[5]}}, ir_q[5:0]};
  assign pc11 = pc_q + {{5{ir_q[10]}}, ir_q[10:0]};

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = maddr_q[AW-1:0];
    ram_wdata = mdata_q;
    unique case (state_q)
      S_FETCH: begin
        if (cmd_q == CMD_WRITE) ram_we = !wait_q;
        else if (cmd_q == CMD_READ) ram_addr = maddr_q[AW-1:0];
        else ram_addr = pc_q[AW-1:0];
      end
      S_PTR:  ram_addr = pc9[AW-1:0];
      S_DATA: begin
        // stores write the held register value at the target
        ram_we = (op == OP_ST) || (op == OP_STR) || (op == OP_STI);
        unique case (op)
          OP_LD:   ram_addr = pc9[AW-1:0];
          OP_LDR:  ram_addr = br6[AW-1:0];
          default: ram_addr = ptr_q[AW-1:0];
        endcase
      end
      default: ;
    endcase
  end

  function automatic result_t blank(input logic [15:0] pc, input logic [2:0] cc);
    result_t r;
    r = '0;
    r.pc_after = pc;
    r.cond_code = cc;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= 16'h3000;
      cc_q     <= CcZ;
      ovalid_q <= 1'b0;
      wait_q   <= 1'b0;
      cmd_q    <= CMD_NONE;
      for (int i = 0; i < 8; i++) rf_q[i] <= '0;
    end else begin
      result_t     r;
      logic [15:0] v;
      r = res_q;
      v = '0;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) pc_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          wait_q <= 1'b0;
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_q   <= s_axis_tdata[1:0];
            maddr_q <= s_axis_tdata[17:2];
            mdata_q <= s_axis_tdata[33:18];
            if (s_axis_tdata[1:0] == CMD_NONE) begin
              res_q    <= blank(pc_q, cc_q);
              ovalid_q <= 1'b1;
            end else begin
              state_q <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (cmd_q == CMD_WRITE) begin
            res_q    <= blank(pc_q, cc_q);
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end else if (!wait_q) begin
            wait_q <= 1'b1;
          end else begin
            wait_q <= 1'b0;
            if (cmd_q == CMD_READ) begin
              r           = blank(pc_q, cc_q);
              r.read_data = ram_rdata;
              res_q      <= r;
              ovalid_q   <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              ir_q    <= ram_rdata;
              pc_q    <= pc_q + 16'd1;
              state_q <= S_DECODE;
            end
          end
        end
        S_DECODE: begin
          r              = blank(pc_q, cc_q);
          r.fetched_word = ir_q;
          r.halted       = (ir_q == HaltWord);
          state_q       <= S_DONE;
          unique case (op)
            OP_BR: if ((dr & cc_q) != 3'b000) begin
              pc_q      <= pc9;
              r.pc_after = pc9;
            end
            OP_ADD, OP_AND, OP_NOT: begin
              v = (op == OP_ADD) ? s1 + v2 : (op == OP_AND) ? (s1 & v2) : ~s1;
              rf_q[dr]     <= v;
              cc_q         <= cc_of(v);
              r.cond_code   = cc_of(v);
              r.reg_written = 1'b1;
              r.reg_number  = dr;
              r.reg_value   = v;
            end
            OP_LEA: begin
              rf_q[dr]     <= pc9;
              r.reg_written = 1'b1;
              r.reg_number  = dr;
              r.reg_value   = pc9;
            end
            OP_ST, OP_STR: begin
              ptr_q   <= (op == OP_ST) ? pc9 : br6;
              mdata_q <= rf_q[dr];
              state_q <= S_DATA;
            end
            OP_LD, OP_LDR: state_q <= S_DATA;
            OP_LDI, OP_STI: begin
              mdata_q <= rf_q[dr];
              state_q <= S_PTR;
            end
            OP_JSR: begin
              rf_q[7]      <= pc_q;
              r.reg_written = 1'b1;
              r.reg_number  = 3'd7;
              r.reg_value   = pc_q;
              pc_q         <= ir_q[11] ? pc11 : s1;
              r.pc_after    = ir_q[11] ? pc11 : s1;
            end
            OP_JMP: begin
              pc_q      <= s1;
              r.pc_after = s1;
            end
            default: ;
          endcase
          res_q <= r;
        end
        S_PTR: begin
          wait_q <= !wait_q;
          if (wait_q) begin
            ptr_q   <= ram_rdata;
            state_q <= S_DATA;
          end
        end
        S_DATA: begin
          if (op == OP_ST || op == OP_STR || op == OP_STI) begin
            r.mem_written   = 1'b1;
            r.store_address = 16'(ptr_q[AW-1:0]);
            r.store_value   = mdata_q;
            res_q          <= r;
            state_q        <= S_DONE;
          end else begin
            wait_q <= !wait_q;
            if (wait_q) begin
              rf_q[dr]     <= ram_rdata;
              cc_q         <= cc_of(ram_rdata);
              r.cond_code   = cc_of(ram_rdata);
              r.reg_written = 1'b1;
              r.reg_number  = dr;
              r.reg_value   = ram_rdata;
              res_q        <= r;
              state_q      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Input is held off while a result beat waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_axis_tready |-> !m_axis_tvalid);

  // Result beat holds steady until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

  // Condition code stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(cc_q));

  // Start PC is only taken while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o |-> state_q == S_IDLE);

endmodule

// File: tb/testbench.sv
// Self-checking bench for lc3_instruction_step: builds command streams, predicts each result
// with an in-bench instruction model and checks every output beat field by field.
// Depends on lc3_pkg and the lc3_instruction_step RTL only.
`timescale 1ns / 100ps

module testbench;
  import lc3_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] addr;
    logic [15:0] data;
  } command_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  // model state
  logic [15:0] mem_q [65536];
  bit          mem_known [65536];
  logic [15:0] known_addrs [$];
  logic [15:0] gpr [8];
  logic [15:0] pc_q;
  logic [2:0]  cc_q;

  command_t    cmd_pending [$];
  result_t     result_due [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;
  bit          in_fire = 1'b0;
  int          quiet_cycles = 0;

  lc3_instruction_step dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [15:0] sx9(logic [15:0] w);
    return {{7{w[8]}}, w[8:0]};
  endfunction

  function void note_write(logic [15:0] a, logic [15:0] d);
    mem_q[a] = d;
    if (!mem_known[a]) begin
      mem_known[a] = 1'b1;
      known_addrs.push_back(a);
    end
  endfunction

  // Executes one command on the model and returns the beat it should produce.
  function result_t execute_command(command_t c);
    result_t     r;
    logic [15:0] ir, pc1, s1, v2, pc9, br6, res, tgt;
    logic [3:0]  op;
    logic [2:0]  dr;
    r = '0;
    case (c.cmd)
      CMD_WRITE: note_write(c.addr, c.data);
      CMD_READ: r.read_data = mem_q[c.addr];
      CMD_STEP: begin
        ir = mem_q[pc_q];
        r.fetched_word = ir;
        pc1 = pc_q + 16'd1;
        pc_q = pc1;
        r.halted = (ir == HaltWord);
        op = ir[15:12];
        dr = ir[11:9];
        s1 = gpr[ir[8:6]];
        v2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
        pc9 = pc1 + sx9(ir);
        br6 = s1 + {{10{ir[5]}}, ir[5:0]};
        case (opcode_e'(op))
          OP_BR: if ((dr & cc_q) != 3'b000) pc_q = pc9;
          OP_ADD, OP_AND, OP_NOT, OP_LD, OP_LDI, OP_LDR: begin
            case (opcode_e'(op))
              OP_ADD:  res = s1 + v2;
              OP_AND:  res = s1 & v2;
              OP_NOT:  res = ~s1;
              OP_LD:   res = mem_q[pc9];
              OP_LDI:  res = mem_q[mem_q[pc9]];
              default: res = mem_q[br6];
            endcase
            r.reg_written = 1'b1; r.reg_number = dr; r.reg_value = res;
            cc_q = (res == 16'h0) ? CcZ : (res[15] ? CcN : CcP);
          end
          OP_LEA: begin
            r.reg_written = 1'b1; r.reg_number = dr; r.reg_value = pc9;
          end
          OP_ST, OP_STI, OP_STR: begin
            tgt = (opcode_e'(op) == OP_ST) ? pc9 :
                  (opcode_e'(op) == OP_STI) ? mem_q[pc9] : br6;
            r.mem_written = 1'b1; r.store_address = tgt; r.store_value = gpr[dr];
          end
          OP_JSR: begin
            // JSRR target is taken before R7 gets the return address
            tgt = ir[11] ? pc1 + {{5{ir[10]}}, ir[10:0]} : s1;
            r.reg_written = 1'b1; r.reg_number = 3'd7; r.reg_value = pc1;
            pc_q = tgt;
          end
          OP_JMP: pc_q = s1;
          default: ;
        endcase
        if (r.reg_written) gpr[r.reg_number] = r.reg_value;
        if (r.mem_written) note_write(r.store_address, r.store_value);
      end
      default: ;
    endcase
    r.pc_after = pc_q;
    r.cond_code = cc_q;
    return r;
  endfunction

  task automatic issue(cmd_e c, logic [15:0] a, logic [15:0] d);
    command_t x;
    x.cmd = c; x.addr = a; x.data = d;
    result_due.push_back(execute_command(x));
    cmd_pending.push_back(x);
  endtask

  // First word the next step would read that was never written; 0 when none.
  function automatic bit find_unwritten(output logic [15:0] a);
    logic [15:0] ir, pc9, br6;
    ir = mem_q[pc_q];
    pc9 = pc_q + 16'd1 + sx9(ir);
    br6 = gpr[ir[8:6]] + {{10{ir[5]}}, ir[5:0]};
    a = pc9;
    case (opcode_e'(ir[15:12]))
      OP_LD, OP_STI: return !mem_known[pc9];
      OP_LDI: begin
        if (!mem_known[pc9]) return 1'b1;
        a = mem_q[pc9];
        return !mem_known[a];
      end
      OP_LDR: begin
        a = br6;
        return !mem_known[br6];
      end
      default: return 1'b0;
    endcase
  endfunction

  // Step one instruction; place the given word at PC when asked or when PC is fresh.
  task automatic step_with(bit place, logic [15:0] word);
    logic [15:0] a;
    if (place || !mem_known[pc_q]) issue(CMD_WRITE, pc_q, word);
    while (find_unwritten(a)) issue(CMD_WRITE, a, 16'($urandom));
    issue(CMD_STEP, 16'h0, 16'h0);
  endtask

  function automatic logic [15:0] random_instr();
    if ($urandom_range(0, 99) < 3) return HaltWord;
    return {4'($urandom_range(0, 15)), 12'($urandom)};
  endfunction

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) issue(CMD_WRITE, 16'($urandom), 16'($urandom));
      else if (k < 14)
        issue(CMD_READ, known_addrs[$urandom_range(0, known_addrs.size() - 1)], 16'($urandom));
      else if (k < 16) issue(CMD_NONE, 16'($urandom), 16'($urandom));
      else step_with(1'b0, random_instr());
    end
  endtask

  task automatic drain();
    wait (cmd_pending.size() == 0 && result_due.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_start_pc(logic [15:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    pc_q = v;
  endtask

  // input driver: hold the beat until it is taken
  always @(posedge clk_i) in_fire <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (in_fire && s_axis_tvalid) void'(cmd_pending.pop_front());
      if (cmd_pending.size() > 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, cmd_pending[0].data, cmd_pending[0].addr, cmd_pending[0].cmd};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random back-pressure and one long hold-off
  always @(negedge clk_i) begin
    if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (result_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      end else begin
        want = result_due.pop_front();
        check_field("read_data", want.read_data, got.read_data);
        check_field("pc_after", want.pc_after, got.pc_after);
        check_field("fetched_word", want.fetched_word, got.fetched_word);
        check_field("cond_code", want.cond_code, got.cond_code);
        check_field("halted", want.halted, got.halted);
        check_field("reg_written", want.reg_written, got.reg_written);
        check_field("reg_number", want.reg_number, got.reg_number);
        check_field("reg_value", want.reg_value, got.reg_value);
        check_field("mem_written", want.mem_written, got.mem_written);
        check_field("store_address", want.store_address, got.store_address);
        check_field("store_value", want.store_value, got.store_value);
      end
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("lc3_instruction_step test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) gpr[i] = 16'h0;
    pc_q = 16'h3000;
    cc_q = CcZ;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, unused command, every opcode
    issue(CMD_WRITE, 16'h0000, 16'hFFFF);
    issue(CMD_WRITE, 16'hFFFF, 16'h0000);
    issue(CMD_READ, 16'h0000, 16'h0000);
    issue(CMD_READ, 16'hFFFF, 16'hFFFF);
    issue(CMD_NONE, 16'hFFFF, 16'hFFFF);
    step_with(1'b1, 16'h0E7F);        // BR always taken with nzp all set
    step_with(1'b1, 16'h1021 | 16'h0E00 | 16'h003F); // ADD R7 = R0 + -1
    step_with(1'b1, 16'h0801);        // BRn taken
    step_with(1'b1, HaltWord);        // halt, later steps still run
    step_with(1'b1, 16'h5020);        // AND R0 = 0
    step_with(1'b1, 16'h927F);        // NOT R1 = ~R1
    step_with(1'b1, 16'h2401);        // LD
    step_with(1'b1, 16'hA601);        // LDI
    step_with(1'b1, 16'h6840);        // LDR
    step_with(1'b1, 16'hEBFF);        // LEA
    step_with(1'b1, 16'h3E05);        // ST
    step_with(1'b1, 16'hBE05);        // STI
    step_with(1'b1, 16'h7FC1);        // STR
    step_with(1'b1, 16'h41C0);        // JSRR through R7
    step_with(1'b1, 16'h4FFF);        // JSR
    step_with(1'b1, 16'hC1C0);        // RET
    step_with(1'b1, 16'h8000);        // RTI
    step_with(1'b1, 16'hD000);        // reserved
    step_with(1'b1, 16'hF0FF);        // other trap

    // PC wrap at the top of the address space
    set_start_pc(16'hFFFF);
    step_with(1'b1, 16'h1000);
    step_with(1'b1, 16'h1000);
    random_phase(100);

    // low start and a long receiver hold-off while commands keep coming
    set_start_pc(16'h0000);
    stall_req = 1'b1;
    random_phase(100);

    set_start_pc(16'($urandom));
    no_idle = 1'b1;
    random_phase(50);
    no_idle = 1'b0;
    random_phase(50);

    wait (cmd_pending.size() == 0 && result_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("lc3_instruction_step test passed");
    else $display("lc3_instruction_step test failed");
    $finish;
  end

endmodule
